// File: src/segi_pkg.sv
// Shared types, widths and register codes of the segment intersection test.
package segi_pkg;

  // Coordinate format: two's complement, Q14.10
  localparam int COORD_WIDTH = 24;
  // Coordinate differences
  localparam int DIFF_W      = COORD_WIDTH + 1;
  // One partial product of a cross product
  localparam int PROD_W      = 2 * DIFF_W;
  // Full cross product
  localparam int ORIENT_W    = PROD_W + 1;
  // Bounding box limits with the tolerance applied
  localparam int BOX_W       = COORD_WIDTH + 2;

  localparam int CROSS_TOL_W = 48;
  localparam int COORD_TOL_W = 16;
  localparam int CFG_DATA_W  = CROSS_TOL_W;
  localparam int CFG_INDEX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CROSS_TOL = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COORD_TOL = 1'd1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [BOX_W-1:0]       lim_t;

  // Input beat: endpoints of segments AB and CD
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by_coord;
    coord_t cx;
    coord_t cy;
    coord_t dx;
    coord_t dy;
  } seg_in_t;

  // Output beat
  typedef struct packed {
    logic intersects;
    logic proper_crossing;
  } seg_out_t;

  // Widened bounding box of one segment
  typedef struct packed {
    lim_t xhi;
    lim_t xlo;
    lim_t yhi;
    lim_t ylo;
  } box_t;

  // After the first stage: edge vectors, endpoint offsets, boxes
  typedef struct packed {
    diff_t   ux;   // B - A
    diff_t   uy;
    diff_t   acx;  // C - A
    diff_t   acy;
    diff_t   adx;  // D - A
    diff_t   ady;
    diff_t   wx;   // D - C
    diff_t   wy;
    diff_t   cax;  // A - C
    diff_t   cay;
    diff_t   cbx;  // B - C
    diff_t   cby;
    box_t    ab;
    box_t    cd;
    seg_in_t pts;
  } s1_t;

  // Box hits for the four endpoint-on-segment tests
  typedef struct packed {
    logic c_in_ab;
    logic d_in_ab;
    logic a_in_cd;
    logic b_in_cd;
  } box_hit_t;

  // After the multiply stage: the two partial products of each cross product
  typedef struct packed {
    prod_t    o1_l;
    prod_t    o1_r;
    prod_t    o2_l;
    prod_t    o2_r;
    prod_t    o3_l;
    prod_t    o3_r;
    prod_t    o4_l;
    prod_t    o4_r;
    box_hit_t hit;
  } s2_t;

  // Difference of two coordinates, one bit wider
  function automatic diff_t coord_sub(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  // Coordinate sign-extended to box width
  function automatic lim_t coord_ext(coord_t a);
    return lim_t'(a);
  endfunction

endpackage

// File: src/segment_intersection_test_core.sv
// Segment intersection test: top level, configuration registers, pipeline wiring.
//
// Decides whether segment AB meets segment CD. Coordinates are signed Q14.10.
// One beat enters per cycle while in_ready is high. There are five register
// stages: differences and boxes, multiply, cross product sums, magnitudes,
// and tolerance compare. Results leave in input order. Every stage holds its
// beat while the one after it is full, so a stalled output backs up stage by
// stage and input is still taken until all five stages are full. proper_crossing
// marks a strict crossing beyond cross_tolerance; intersects also covers an
// endpoint that lies on the other segment within cross_tolerance and inside
// its bounding box widened by coord_tolerance. Change the registers only while
// the pipeline is empty.
module segment_intersection_test_core import segi_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  seg_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output seg_out_t               out_data
);

  localparam int PIPE_DEPTH = 5;
  localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

  logic [CROSS_TOL_W-1:0] cross_tol;
  logic [COORD_TOL_W-1:0] coord_tol;

  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  s1_t  s1_data;
  s2_t  s2_data;

  logic [OCC_W-1:0] occ, occ_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cross_tol <= '0;
      coord_tol <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CROSS_TOL: cross_tol <= cfg_data[CROSS_TOL_W-1:0];
        REG_COORD_TOL: coord_tol <= cfg_data[COORD_TOL_W-1:0];
        default: ;
      endcase
    end
  end

  segi_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .coord_tol (coord_tol),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_data   (s1_data)
  );

  segi_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_data  (s1_data),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_data  (s2_data)
  );

  segi_class u_class (
    .clk       (clk),
    .rst       (rst),
    .cross_tol (cross_tol),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2_data   (s2_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Beats in flight, for checking
  assign occ_next = occ + OCC_W'(in_valid && in_ready) - OCC_W'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // A strict crossing is always an intersection
  a_proper_hits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.proper_crossing || out_data.intersects))
    else $error("proper_crossing without intersects");

  // The input only stalls when the output is holding a beat
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no output beat pending");

  // Never more beats in flight than pipeline stages
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(PIPE_DEPTH))
    else $error("more beats in flight than stages");

  // A full pipeline with a stalled output refuses input
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (occ == OCC_W'(PIPE_DEPTH) && !out_ready) |-> !in_ready)
    else $error("input open with all stages full and output stalled");

  // Output empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && occ == '0))
    else $error("pipeline not empty after reset");

endmodule

// File: src/segi_prep.sv
// First pipeline stage: coordinate differences and widened bounding boxes.
module segi_prep import segi_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [COORD_TOL_W-1:0] coord_tol,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  seg_in_t                in_data,
  output logic                   s1_valid,
  input  logic                   s1_ready,
  output s1_t                    s1_data
);

  s1_t  s1_next;
  lim_t tol;

  assign tol      = lim_t'({1'b0, coord_tol});
  assign in_ready = !s1_valid || s1_ready;

  // Differences and boxes
  always_comb begin
    s1_next.ux  = coord_sub(in_data.bx, in_data.ax);
    s1_next.uy  = coord_sub(in_data.by_coord, in_data.ay);
    s1_next.acx = coord_sub(in_data.cx, in_data.ax);
    s1_next.acy = coord_sub(in_data.cy, in_data.ay);
    s1_next.adx = coord_sub(in_data.dx, in_data.ax);
    s1_next.ady = coord_sub(in_data.dy, in_data.ay);
    s1_next.wx  = coord_sub(in_data.dx, in_data.cx);
    s1_next.wy  = coord_sub(in_data.dy, in_data.cy);
    s1_next.cax = coord_sub(in_data.ax, in_data.cx);
    s1_next.cay = coord_sub(in_data.ay, in_data.cy);
    s1_next.cbx = coord_sub(in_data.bx, in_data.cx);
    s1_next.cby = coord_sub(in_data.by_coord, in_data.cy);

    s1_next.ab.xhi = coord_ext((in_data.ax > in_data.bx) ? in_data.ax : in_data.bx) + tol;
    s1_next.ab.xlo = coord_ext((in_data.ax < in_data.bx) ? in_data.ax : in_data.bx) - tol;
    s1_next.ab.yhi = coord_ext((in_data.ay > in_data.by_coord) ? in_data.ay
                                                               : in_data.by_coord) + tol;
    s1_next.ab.ylo = coord_ext((in_data.ay < in_data.by_coord) ? in_data.ay
                                                               : in_data.by_coord) - tol;
    s1_next.cd.xhi = coord_ext((in_data.cx > in_data.dx) ? in_data.cx : in_data.dx) + tol;
    s1_next.cd.xlo = coord_ext((in_data.cx < in_data.dx) ? in_data.cx : in_data.dx) - tol;
    s1_next.cd.yhi = coord_ext((in_data.cy > in_data.dy) ? in_data.cy : in_data.dy) + tol;
    s1_next.cd.ylo = coord_ext((in_data.cy < in_data.dy) ? in_data.cy : in_data.dy) - tol;

    s1_next.pts = in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= s1_next;
    end
  end

endmodule

// File: src/segi_mul.sv
// Second pipeline stage: eight partial products and the bounding box compares.
module segi_mul import segi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s1_valid,
  output logic s1_ready,
  input  s1_t  s1_data,
  output logic s2_valid,
  input  logic s2_ready,
  output s2_t  s2_data
);

  s2_t s2_next;

  assign s1_ready = !s2_valid || s2_ready;

  // Is point (x, y) inside box b
  function automatic logic in_box(box_t b, coord_t x, coord_t y);
    lim_t ex;
    lim_t ey;
    ex = coord_ext(x);
    ey = coord_ext(y);
    return (ex <= b.xhi) && (ex >= b.xlo) && (ey <= b.yhi) && (ey >= b.ylo);
  endfunction

  // Cross products split as left minus right term
  always_comb begin
    s2_next.o1_l = prod_t'(s1_data.ux) * prod_t'(s1_data.acy);
    s2_next.o1_r = prod_t'(s1_data.uy) * prod_t'(s1_data.acx);
    s2_next.o2_l = prod_t'(s1_data.ux) * prod_t'(s1_data.ady);
    s2_next.o2_r = prod_t'(s1_data.uy) * prod_t'(s1_data.adx);
    s2_next.o3_l = prod_t'(s1_data.wx) * prod_t'(s1_data.cay);
    s2_next.o3_r = prod_t'(s1_data.wy) * prod_t'(s1_data.cax);
    s2_next.o4_l = prod_t'(s1_data.wx) * prod_t'(s1_data.cby);
    s2_next.o4_r = prod_t'(s1_data.wy) * prod_t'(s1_data.cbx);

    s2_next.hit.c_in_ab = in_box(s1_data.ab, s1_data.pts.cx, s1_data.pts.cy);
    s2_next.hit.d_in_ab = in_box(s1_data.ab, s1_data.pts.dx, s1_data.pts.dy);
    s2_next.hit.a_in_cd = in_box(s1_data.cd, s1_data.pts.ax, s1_data.pts.ay);
    s2_next.hit.b_in_cd = in_box(s1_data.cd, s1_data.pts.bx, s1_data.pts.by_coord);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2_data <= s2_next;
    end
  end

endmodule

// File: src/segi_class.sv
// Last three stages: cross product sums, magnitudes, tolerance compare and verdict.
module segi_class import segi_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CROSS_TOL_W-1:0] cross_tol,
  input  logic                   s2_valid,
  output logic                   s2_ready,
  input  s2_t                    s2_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output seg_out_t               out_data
);

  localparam int CMP_W = (ORIENT_W > CROSS_TOL_W) ? ORIENT_W : CROSS_TOL_W;

  typedef logic signed [ORIENT_W-1:0] orient_t;
  typedef logic [ORIENT_W-1:0]        mag_t;

  typedef struct packed {
    orient_t  o1;
    orient_t  o2;
    orient_t  o3;
    orient_t  o4;
    box_hit_t hit;
  } s3_t;

  typedef struct packed {
    mag_t     m1;
    mag_t     m2;
    mag_t     m3;
    mag_t     m4;
    logic     n1;
    logic     n2;
    logic     n3;
    logic     n4;
    box_hit_t hit;
  } s4_t;

  logic     s3_valid, s4_valid;
  logic     s3_ready, s4_ready;
  s3_t      s3_data, s3_next;
  s4_t      s4_data, s4_next;
  seg_out_t out_next;

  logic [CMP_W-1:0] tol;
  logic             big1, big2, big3, big4;
  logic             proper;

  // Ready chain: a stage moves when it is empty or its successor moves
  assign s4_ready = !out_valid || out_ready;
  assign s3_ready = !s4_valid || s4_ready;
  assign s2_ready = !s3_valid || s3_ready;

  function automatic mag_t abs_val(orient_t v);
    return v[ORIENT_W-1] ? mag_t'(~v + orient_t'(1)) : mag_t'(v);
  endfunction

  // Stage 3: cross products
  always_comb begin
    s3_next.o1  = orient_t'(s2_data.o1_l) - orient_t'(s2_data.o1_r);
    s3_next.o2  = orient_t'(s2_data.o2_l) - orient_t'(s2_data.o2_r);
    s3_next.o3  = orient_t'(s2_data.o3_l) - orient_t'(s2_data.o3_r);
    s3_next.o4  = orient_t'(s2_data.o4_l) - orient_t'(s2_data.o4_r);
    s3_next.hit = s2_data.hit;
  end

  // Stage 4: sign and magnitude
  always_comb begin
    s4_next.m1  = abs_val(s3_data.o1);
    s4_next.m2  = abs_val(s3_data.o2);
    s4_next.m3  = abs_val(s3_data.o3);
    s4_next.m4  = abs_val(s3_data.o4);
    s4_next.n1  = s3_data.o1[ORIENT_W-1];
    s4_next.n2  = s3_data.o2[ORIENT_W-1];
    s4_next.n3  = s3_data.o3[ORIENT_W-1];
    s4_next.n4  = s3_data.o4[ORIENT_W-1];
    s4_next.hit = s3_data.hit;
  end

  // Stage 5: a magnitude above the tolerance implies a nonzero sign
  assign tol  = CMP_W'(cross_tol);
  assign big1 = CMP_W'(s4_data.m1) > tol;
  assign big2 = CMP_W'(s4_data.m2) > tol;
  assign big3 = CMP_W'(s4_data.m3) > tol;
  assign big4 = CMP_W'(s4_data.m4) > tol;

  // Touch tests use the same cross products, with the magnitude not above the tolerance
  assign proper = big1 && big2 && (s4_data.n1 != s4_data.n2) &&
                  big3 && big4 && (s4_data.n3 != s4_data.n4);

  always_comb begin
    out_next.proper_crossing = proper;
    out_next.intersects      = proper ||
                               (s4_data.hit.c_in_ab && !big1) ||
                               (s4_data.hit.d_in_ab && !big2) ||
                               (s4_data.hit.a_in_cd && !big3) ||
                               (s4_data.hit.b_in_cd && !big4);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_ready) begin
        s3_valid <= s2_valid;
      end
      if (s3_ready) begin
        s4_valid <= s3_valid;
      end
      if (s4_ready) begin
        out_valid <= s4_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      s3_data <= s3_next;
    end
    if (s3_ready && s3_valid) begin
      s4_data <= s4_next;
    end
    if (s4_ready && s4_valid) begin
      out_data <= out_next;
    end
  end

endmodule

// File: test/segment_intersection_test_core_tb.sv
// Testbench for segment_intersection_test_core: directed table, then random segment pairs.
module segment_intersection_test_core_tb;
  import segi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     PHASES         = 10;
  localparam int     PHASE_ITEMS    = 110;
  localparam int     PRESSURE_PHASE = 3;
  localparam int     HOLD_CYCLES    = 200;
  localparam int     SETTLE_CYCLES  = 8;
  localparam int     DRAIN_CYCLES   = 20;
  localparam int     DIR_N          = 14;
  localparam coord_t CMAX           = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN           = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // One directed row: the segment pair, and a verdict typed in where it is obvious
  typedef struct packed {
    seg_in_t  pts;
    logic     known;
    seg_out_t want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // everything at the origin
    '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{1'b1, 1'b0}},
    // plain X crossing
    '{'{-100, 0, 100, 0, 0, -100, 0, 100}, 1'b1, '{1'b1, 1'b1}},
    // full-range diagonals
    '{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b1, '{1'b1, 1'b1}},
    // parallel, apart
    '{'{0, 0, 100, 0, 0, 50, 100, 50}, 1'b1, '{1'b0, 1'b0}},
    // T junction: C sits on AB
    '{'{-100, 0, 100, 0, 0, 0, 0, 100}, 1'b1, '{1'b1, 1'b0}},
    // collinear, overlapping
    '{'{0, 0, 100, 0, 50, 0, 150, 0}, 1'b1, '{1'b1, 1'b0}},
    // collinear, apart
    '{'{0, 0, 100, 0, 200, 0, 300, 0}, 1'b1, '{1'b0, 1'b0}},
    // zero-length AB lying on CD
    '{'{50, 0, 50, 0, 0, 0, 100, 0}, 1'b1, '{1'b1, 1'b0}},
    // zero-length AB off CD
    '{'{50, 10, 50, 10, 0, 0, 100, 0}, 1'b1, '{1'b0, 1'b0}},
    // all points at the top corner
    '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1, '{1'b1, 1'b0}},
    // all points at the bottom corner
    '{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1, '{1'b1, 1'b0}},
    // full-height verticals at opposite edges
    '{'{CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX}, 1'b1, '{1'b0, 1'b0}},
    // near miss by one LSB
    '{'{0, 0, 100, 0, 100, 1, 200, 1}, 1'b1, '{1'b0, 1'b0}},
    // full-range axes through the origin
    '{'{CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX}, 1'b0, '{1'b0, 1'b0}}
  };

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  seg_in_t                in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  seg_out_t               out_data;

  // Local copy of the tolerance registers
  longint   tol_cross      = 0;
  longint   tol_coord      = 0;
  seg_out_t verdict_q [$];
  int       mismatch_count = 0;
  bit       tx_burst       = 1'b0;
  bit       rx_burst       = 1'b0;
  bit       pressure       = 1'b0;
  bit       hold_req       = 1'b0;

  segment_intersection_test_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("segment_intersection_test_core_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Verdict predictor
  // ---------------------------------------------------------------------------

  // (q - p) x (r - p)
  function automatic longint cross_of(longint px, longint py, longint qx, longint qy,
                                      longint rx, longint ry);
    return (qx - px) * (ry - py) - (qy - py) * (rx - px);
  endfunction

  function automatic longint abs_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit above_tol(longint v);
    return v > 0 && v > tol_cross;
  endfunction

  function automatic bit below_tol(longint v);
    return v < 0 && -v > tol_cross;
  endfunction

  // strictly opposite signs beyond the cross tolerance
  function automatic bit straddles(longint v, longint w);
    return (above_tol(v) && below_tol(w)) || (below_tol(v) && above_tol(w));
  endfunction

  // q inside the widened box of segment pr and collinear with it
  function automatic bit lies_on(longint px, longint py, longint qx, longint qy,
                                 longint rx, longint ry);
    longint t;
    t = tol_coord;
    return qx <= ((px > rx) ? px : rx) + t && qx + t >= ((px < rx) ? px : rx) &&
           qy <= ((py > ry) ? py : ry) + t && qy + t >= ((py < ry) ? py : ry) &&
           abs_of(cross_of(px, py, qx, qy, rx, ry)) <= tol_cross;
  endfunction

  function automatic seg_out_t seg_verdict(seg_in_t s);
    longint   ax, ay, bx, by, cx, cy, dx, dy;
    bit       crossing;
    seg_out_t v;
    ax = longint'($signed(s.ax));
    ay = longint'($signed(s.ay));
    bx = longint'($signed(s.bx));
    by = longint'($signed(s.by_coord));
    cx = longint'($signed(s.cx));
    cy = longint'($signed(s.cy));
    dx = longint'($signed(s.dx));
    dy = longint'($signed(s.dy));
    crossing = straddles(cross_of(ax, ay, bx, by, cx, cy), cross_of(ax, ay, bx, by, dx, dy)) &&
               straddles(cross_of(cx, cy, dx, dy, ax, ay), cross_of(cx, cy, dx, dy, bx, by));
    v.proper_crossing = crossing;
    v.intersects      = crossing ||
                        lies_on(ax, ay, cx, cy, bx, by) || lies_on(ax, ay, dx, dy, bx, by) ||
                        lies_on(cx, cy, ax, ay, dx, dy) || lies_on(cx, cy, bx, by, dx, dy);
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Random segment pairs
  // ---------------------------------------------------------------------------

  function automatic coord_t shift(coord_t c, int d);
    return coord_t'(int'(c) + d);
  endfunction

  function automatic coord_t around(coord_t c, int span);
    return shift(c, int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // mostly exact, sometimes a couple of LSBs off
  function automatic int jitter();
    return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 4)) - 2;
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 6))
      0: return CMIN;
      1: return CMAX;
      2: return '0;
      3: return '1;
      4: return shift(CMIN, 1);
      5: return shift(CMAX, -1);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic seg_in_t random_pair();
    seg_in_t s;
    coord_t  ox, oy;
    int      kind, ux, uy, k0, k1, k2, k3, r0, r1, r2, r3;
    kind = $urandom_range(0, 9);
    ox = coord_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
    oy = coord_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
    ux = int'($urandom_range(0, 128)) - 64;
    uy = int'($urandom_range(0, 128)) - 64;
    k0 = int'($urandom_range(0, 128)) - 64;
    k1 = int'($urandom_range(0, 128)) - 64;
    k2 = int'($urandom_range(0, 128)) - 64;
    k3 = int'($urandom_range(0, 128)) - 64;
    r0 = $urandom_range(0, 300);
    r1 = $urandom_range(0, 300);
    r2 = $urandom_range(0, 300);
    r3 = $urandom_range(0, 300);
    case (kind)
      // noise over the whole coordinate range
      0, 1: s = seg_in_t'({$urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom()});
      // all four points in a small window
      2, 3: s = '{around(ox, 32), around(oy, 32), around(ox, 32), around(oy, 32),
                  around(ox, 32), around(oy, 32), around(ox, 32), around(oy, 32)};
      // four points on one line, slightly perturbed
      4, 5: s = '{shift(ox, k0 * ux + jitter()), shift(oy, k0 * uy + jitter()),
                  shift(ox, k1 * ux + jitter()), shift(oy, k1 * uy + jitter()),
                  shift(ox, k2 * ux + jitter()), shift(oy, k2 * uy + jitter()),
                  shift(ox, k3 * ux + jitter()), shift(oy, k3 * uy + jitter())};
      // C at or near a point of AB, D anywhere close
      6: begin
        k0 = $urandom_range(1, 64);
        k1 = $urandom_range(0, k0);
        s.ax = ox;
        s.ay = oy;
        s.bx = shift(ox, k0 * ux);
        s.by_coord = shift(oy, k0 * uy);
        s.cx = shift(ox, k1 * ux + jitter());
        s.cy = shift(oy, k1 * uy + jitter());
        s.dx = around(s.cx, 200);
        s.dy = around(s.cy, 200);
        if ($urandom_range(0, 1) == 1)
          s = '{s.dx, s.dy, s.cx, s.cy, s.ax, s.ay, s.bx, s.by_coord};
        if ($urandom_range(0, 1) == 1)
          s = '{s.bx, s.by_coord, s.ax, s.ay, s.cx, s.cy, s.dx, s.dy};
      end
      // zero-length segments
      7: begin
        s = '{around(ox, 16), around(oy, 16), around(ox, 16), around(oy, 16),
              around(ox, 16), around(oy, 16), around(ox, 16), around(oy, 16)};
        case ($urandom_range(0, 2))
          0: begin s.bx = s.ax; s.by_coord = s.ay; end
          1: begin s.dx = s.cx; s.dy = s.cy; end
          default: begin
            s.bx = s.ax; s.by_coord = s.ay;
            s.dx = s.cx; s.dy = s.cy;
          end
        endcase
      end
      // range extremes
      8: s = '{extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
               extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord()};
      // built X shape around a center
      default: s = '{shift(ox, -r0), shift(oy, -r1),
                     shift(ox, r0 + jitter()), shift(oy, r1),
                     shift(ox, -r2), shift(oy, r3),
                     shift(ox, r2), shift(oy, -r3 + jitter())};
    endcase
    return s;
  endfunction

  function automatic logic [CROSS_TOL_W-1:0] pick_cross_tol();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CROSS_TOL_W'($urandom_range(0, 16));
      2: return CROSS_TOL_W'($urandom_range(0, 1 << 16));
      3: return CROSS_TOL_W'({$urandom(), $urandom()});
      default: return '1;
    endcase
  endfunction

  function automatic logic [COORD_TOL_W-1:0] pick_coord_tol();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return COORD_TOL_W'($urandom_range(1, 4));
      2: return COORD_TOL_W'($urandom_range(0, 65535));
      default: return '1;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Register write; the caller drops cfg_we after the last one
  task automatic load_tolerance(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_CROSS_TOL)
      tol_cross = longint'(data[CROSS_TOL_W-1:0]);
    else if (idx == REG_COORD_TOL)
      tol_coord = longint'(data[COORD_TOL_W-1:0]);
    @(posedge clk);
  endtask

  // Offer one input beat and record its verdict once it is taken
  task automatic offer_beat(input seg_in_t pts, input bit typed, input seg_out_t typed_want);
    int       gap;
    seg_out_t expected;
    gap = (pressure || tx_burst) ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 19) == 0)
      tx_burst = !tx_burst;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pts;
    do @(posedge clk); while (!in_ready);
    expected = typed ? typed_want : seg_verdict(pts);
    verdict_q.insert(verdict_q.size(), expected);
  endtask

  // Stop offering, let the pipeline empty out
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result sink: random back-pressure, one long hold on request, checks each beat
  initial begin : result_sink
    int       gap;
    seg_out_t got;
    seg_out_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 11);
      end
      if ($urandom_range(0, 19) == 0)
        rx_burst = !rx_burst;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      if (verdict_q.size() == 0) begin
        $display("%0t: result beat with nothing expected (intersects %0b, proper_crossing %0b)",
                 $time, got.intersects, got.proper_crossing);
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (got.intersects !== want.intersects) begin
          $display("%0t: intersects expected %0b, got %0b",
                   $time, want.intersects, got.intersects);
          mismatch_count++;
        end
        if (got.proper_crossing !== want.proper_crossing) begin
          $display("%0t: proper_crossing expected %0b, got %0b",
                   $time, want.proper_crossing, got.proper_crossing);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus: directed table twice (reset and widest tolerances), then random phases
  initial begin : stimulus
    int sweep;
    int i;
    int ph;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (sweep = 0; sweep < 2; sweep++) begin
      if (sweep == 1) begin
        settle_idle();
        load_tolerance(REG_CROSS_TOL, '1);
        load_tolerance(REG_COORD_TOL, '1);
        cfg_we <= 1'b0;
      end
      // typed verdicts hold only for the reset tolerances
      for (i = 0; i < DIR_N; i++)
        offer_beat(DIR_ROWS[i].pts, sweep == 0 && DIR_ROWS[i].known, DIR_ROWS[i].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle_idle();
      case (ph)
        0: begin
          load_tolerance(REG_CROSS_TOL, '0);
          load_tolerance(REG_COORD_TOL, '0);
        end
        1: begin
          load_tolerance(REG_CROSS_TOL, '1);
          load_tolerance(REG_COORD_TOL, {{(CFG_DATA_W-COORD_TOL_W){1'b1}}, 16'hFFFF});
        end
        default: begin
          load_tolerance(REG_CROSS_TOL, pick_cross_tol());
          // upper data bits are junk for the narrow register
          load_tolerance(REG_COORD_TOL, {$urandom(), pick_coord_tol()});
        end
      endcase
      cfg_we <= 1'b0;
      pressure = (ph == PRESSURE_PHASE);
      if (pressure)
        hold_req = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++)
        offer_beat(random_pair(), 1'b0, '0);
    end
    pressure = 1'b0;

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("segment_intersection_test_core_tb: done, clean");
    else
      $display("segment_intersection_test_core_tb: done, errors");
    $finish;
  end

endmodule

// File: sim.f
src/segi_pkg.sv
src/segi_prep.sv
src/segi_mul.sv
src/segi_class.sv
src/segment_intersection_test_core.sv
test/segment_intersection_test_core_tb.sv
